/* rtl/core/bmap_pkg.sv */
// Shared types, codes and constants for the bank mapper core.
`timescale 1ns / 1ps

package bmap_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    CMD_BUS_WRITE = 2'd0,
    CMD_CPU_TICK  = 2'd1,
    CMD_PPU_TICK  = 2'd2
  } cmd_e;

  // Address areas, taken from CPU address bits 15..12
  localparam logic [3:0] AREA_PRG16 = 4'h8;
  localparam logic [3:0] AREA_MIRR  = 4'hB;
  localparam logic [3:0] AREA_PRG8  = 4'hC;
  localparam logic [3:0] AREA_CHR_LO = 4'hD;
  localparam logic [3:0] AREA_CHR_HI = 4'hE;
  localparam logic [3:0] AREA_IRQ   = 4'hF;

  // Register indexes inside an area
  localparam logic [1:0] REG_IRQ_LATCH = 2'd0;
  localparam logic [1:0] REG_IRQ_CTRL  = 2'd1;
  localparam logic [1:0] REG_IRQ_ACK   = 2'd2;
  localparam logic [1:0] REG_MIRR      = 2'd3;

  // Configuration register index (word address bit)
  localparam logic CFG_REG_REVISION = 1'b0;

  // Reset values and counter constants
  localparam logic [7:0]        PRG8_RESET      = 8'hFE;
  localparam logic [7:0]        COUNT_WRAP      = 8'hFF;
  localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
  localparam logic signed [9:0] PRESCALE_STEP   = 10'sd2;

  // Widths of the ports
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned PADDR_W    = 3;

  typedef logic signed [9:0] prescale_t;

  // Qualified IRQ events for one accepted item
  typedef struct packed {
    logic       latch_we;
    logic       ctrl_we;
    logic       ack_we;
    logic       cpu_tick;
    logic       ppu_tick;
    logic [7:0] data;
  } bmap_irq_ev_t;

endpackage

/* rtl/core/bmap_irq.sv */
// IRQ latch, control, prescaler and 8-bit counter of the bank mapper.
`timescale 1ns / 1ps

module bmap_irq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmap_pkg::bmap_irq_ev_t ev_i,
  output logic                  irq_o
);
  import bmap_pkg::*;

  logic [7:0] latch_q, latch_d;
  logic [7:0] count_q, count_d;
  logic [2:0] ctrl_q, ctrl_d;
  prescale_t  prescale_q, prescale_d;
  prescale_t  prescale_dec;
  logic       pending_q, pending_d;
  logic       clock_cnt;

  // Decide register updates for one transaction
  always_comb begin
    latch_d      = latch_q;
    count_d      = count_q;
    ctrl_d       = ctrl_q;
    prescale_d   = prescale_q;
    pending_d    = pending_q;
    clock_cnt    = 1'b0;
    prescale_dec = prescale_q - PRESCALE_STEP;

    if (ev_i.latch_we) begin
      latch_d = ev_i.data;
    end

    if (ev_i.ctrl_we) begin
      ctrl_d    = ev_i.data[2:0];
      pending_d = 1'b0;
      if (ev_i.data[1]) begin
        count_d    = latch_q;
        prescale_d = PRESCALE_RELOAD;
      end
    end

    // Acknowledge: enable takes the enable-after-ack bit
    if (ev_i.ack_we) begin
      pending_d = 1'b0;
      ctrl_d    = {ctrl_q[2], ctrl_q[0], ctrl_q[0]};
    end

    // Cycle mode: count every CPU tick
    if (ev_i.cpu_tick && ctrl_q[1] && ctrl_q[2]) begin
      clock_cnt = 1'b1;
    end

    // Scanline mode: prescaler drops by two per PPU tick
    if (ev_i.ppu_tick && ctrl_q[1] && !ctrl_q[2]) begin
      if (prescale_dec[9] || (prescale_dec == '0)) begin
        prescale_d = prescale_dec + PRESCALE_RELOAD;
        clock_cnt  = 1'b1;
      end else begin
        prescale_d = prescale_dec;
      end
    end

    // Wrap reloads from the latch and raises the request
    if (clock_cnt) begin
      if (count_q == COUNT_WRAP) begin
        count_d   = latch_q;
        pending_d = 1'b1;
      end else begin
        count_d = count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q    <= '0;
      count_q    <= '0;
      ctrl_q     <= '0;
      prescale_q <= '0;
      pending_q  <= 1'b0;
    end else begin
      latch_q    <= latch_d;
      count_q    <= count_d;
      ctrl_q     <= ctrl_d;
      prescale_q <= prescale_d;
      pending_q  <= pending_d;
    end
  end

  assign irq_o = pending_q;

`ifndef SYNTHESIS
  a_clear_on_ctrl_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_i.ctrl_we || ev_i.ack_we) |=> !pending_q)
    else $error("IRQ not cleared by control or acknowledge write");

  a_rise_from_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> ($past(count_q) == COUNT_WRAP))
    else $error("IRQ raised without counter wrap");

  a_prescale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prescale_q <= PRESCALE_RELOAD) && (prescale_q >= -PRESCALE_STEP))
    else $error("prescaler left its range");
`endif

endmodule

/* rtl/core/bank_mapper_with_scanline_irq_core.sv */
// Top level of the cartridge bank mapper with IRQ counter.
`timescale 1ns / 1ps

// Takes one item per clock: a CPU bus write, a CPU cycle tick or a PPU cycle
// tick (input tuser), and returns one result per item on the output stream:
// the IRQ line, both PRG banks, the eight CHR banks and the mirroring mode as
// they stand after that item. The bank and IRQ registers are themselves the
// result register, so a result is valid in the cycle after its item is taken and
// a new item is taken in every cycle in which the previous result is taken or
// none is waiting. The APB port holds the revision bit that swaps A0 and A1 in
// the register decode; write it only while the block is idle.
module bank_mapper_with_scanline_irq_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: address[15:0], write_data[23:16]
  input  logic [bmap_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: command[1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  // Output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: irq_line[0], prg16_bank[8:1], prg8_bank[16:9], chr_bank_0..7 at
  // [24:17] up to [80:73], mirroring[82:81], zeros above
  output logic [bmap_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmap_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bmap_pkg::*;

  logic         revision_q;
  logic         cfg_we;
  logic         s_accept;
  logic         m_valid_q;
  cmd_e         cmd;
  logic [15:0]  addr;
  logic [7:0]   wdata;
  logic [3:0]   area;
  logic [1:0]   reg_idx;
  logic         bus_we;
  logic [7:0]   prg16_q;
  logic [7:0]   prg8_q;
  logic [7:0]   chr_q [8];
  logic [1:0]   mirr_q;
  logic         irq;
  bmap_irq_ev_t irq_ev;

  // APB register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_REG_REVISION);
  assign prdata = (paddr[2] == CFG_REG_REVISION) ? {31'd0, revision_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      revision_q <= 1'b0;
    end else if (cfg_we) begin
      revision_q <= pwdata[0];
    end
  end

  // Stream handshake: take an item when the result slot is free or draining
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Decode the item
  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign addr    = s_axis_tdata_i[15:0];
  assign wdata   = s_axis_tdata_i[23:16];
  assign area    = addr[15:12];
  assign reg_idx = revision_q ? {addr[0], addr[1]} : addr[1:0];
  assign bus_we  = s_accept && (cmd == CMD_BUS_WRITE);

  // Route IRQ events to the counter unit
  always_comb begin
    irq_ev          = '0;
    irq_ev.data     = wdata;
    irq_ev.latch_we = bus_we && (area == AREA_IRQ) && (reg_idx == REG_IRQ_LATCH);
    irq_ev.ctrl_we  = bus_we && (area == AREA_IRQ) && (reg_idx == REG_IRQ_CTRL);
    irq_ev.ack_we   = bus_we && (area == AREA_IRQ) && (reg_idx == REG_IRQ_ACK);
    unique case (cmd)
      CMD_CPU_TICK: irq_ev.cpu_tick = s_accept;
      CMD_PPU_TICK: irq_ev.ppu_tick = s_accept;
      default:      ;
    endcase
  end

  // Bank and mirroring registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg16_q <= '0;
      prg8_q  <= PRG8_RESET;
      mirr_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= '0;
      end
    end else if (bus_we) begin
      if (area == AREA_PRG16) begin
        prg16_q <= wdata;
      end
      if ((area == AREA_MIRR) && (reg_idx == REG_MIRR)) begin
        mirr_q <= wdata[3:2];
      end
      if (area == AREA_PRG8) begin
        prg8_q <= wdata;
      end
      if (area == AREA_CHR_LO) begin
        chr_q[{1'b0, reg_idx}] <= wdata;
      end
      if (area == AREA_CHR_HI) begin
        chr_q[{1'b1, reg_idx}] <= wdata;
      end
    end
  end

  bmap_irq u_irq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (irq_ev),
    .irq_o  (irq)
  );

  // Result: state after the last accepted item
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, mirr_q,
                            chr_q[7], chr_q[6], chr_q[5], chr_q[4],
                            chr_q[3], chr_q[2], chr_q[1], chr_q[0],
                            prg8_q, prg16_q, irq};

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid_o)
    else $error("accepted item gave no result");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("state changed under a stalled result");

  a_revision_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (revision_q == $past(pwdata[0])))
    else $error("revision register not written");
`endif

endmodule
